>>> hw/rtl/pid_speed_controller_top_macros.svh
// Assertion macros shared by the controller RTL.
`ifndef PID_SPEED_CONTROLLER_TOP_MACROS_SVH
`define PID_SPEED_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH
// prop must hold at every rising clock edge outside reset
`define PSC_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
// cond must never be true outside reset
`define PSC_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden condition");
`else
`define PSC_ASSERT(name, clk, rstn, prop)
`define PSC_NEVER(name, clk, rstn, cond)
`endif

`endif

>>> hw/rtl/psc_pkg.sv
package psc_pkg;

    // defaults for the top-level parameters
    localparam int SPEED_WIDTH_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int DRIVE_MAX_DEF      = 800;
    localparam int COMPARE_OFFSET_DEF = 200;

    localparam int GAIN_W       = 16;  // Q8.8 gain registers
    localparam int INTEG_W      = 32;  // saturating error integral
    localparam int DRIVE_FRAC_W = 8;   // fraction bits of the drive
    localparam int OUT_W        = 10;  // compare_value / drive_level
    localparam int CFG_ADDR_W   = 2;
    localparam int QUEUE_DEPTH  = 4;

    // m_tdata: compare_value, drive_level, clamped, zero fill
    localparam int M_FIELDS_W = 2 * OUT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2
    } psc_reg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } psc_gains_t;

endpackage

>>> hw/rtl/psc_front.sv
module psc_front import psc_pkg::*; #(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
    localparam int EW         = SPEED_WIDTH + 1,
    localparam int DW         = SPEED_WIDTH + 2,
    localparam int ENTRY_W    = EW + INTEG_W + DW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic signed [SPEED_WIDTH-1:0] target_speed,
    input  logic signed [SPEED_WIDTH-1:0] measured_speed,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [ENTRY_W-1:0]            q_push_data
);

    localparam int IW = (SPEED_WIDTH + 2 > INTEG_W + 1) ? SPEED_WIDTH + 2 : INTEG_W + 1;

    logic signed [INTEG_W-1:0] integral_reg, integral_next;
    logic signed [EW-1:0]      prev_err_reg, prev_err_next;
    logic signed [EW-1:0]      err;
    logic signed [DW-1:0]      derr;
    logic signed [IW-1:0]      integ_wide;
    logic [IW-INTEG_W:0]       integ_top;
    logic                      accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    assign err  = {target_speed[SPEED_WIDTH-1], target_speed}
                - {measured_speed[SPEED_WIDTH-1], measured_speed};
    assign derr = {err[EW-1], err} - {prev_err_reg[EW-1], prev_err_reg};

    assign integ_wide = {{(IW-INTEG_W){integral_reg[INTEG_W-1]}}, integral_reg}
                      + {{(IW-EW){err[EW-1]}}, err};
    assign integ_top  = integ_wide[IW-1:INTEG_W-1];

    always_comb begin
        if ((&integ_top) || !(|integ_top)) begin
            integral_next = integ_wide[INTEG_W-1:0];
        end else if (integ_wide[IW-1]) begin
            integral_next = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            integral_next = {1'b0, {(INTEG_W-1){1'b1}}};
        end
        prev_err_next = err;
    end

    assign q_push_data = {derr, integral_next, err};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end else if (accept) begin
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

>>> hw/rtl/psc_queue.sv
module psc_queue import psc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

`include "pid_speed_controller_top_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `PSC_NEVER(a_q_no_overflow, aclk, aresetn, push && full)
    `PSC_NEVER(a_q_no_underflow, aclk, aresetn, pop && empty)

endmodule

>>> hw/rtl/psc_back.sv
module psc_back import psc_pkg::*; #(
    parameter int SPEED_WIDTH    = SPEED_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int DRIVE_MAX      = DRIVE_MAX_DEF,
    parameter int COMPARE_OFFSET = COMPARE_OFFSET_DEF,
    localparam int EW            = SPEED_WIDTH + 1,
    localparam int DW            = SPEED_WIDTH + 2,
    localparam int ENTRY_W       = EW + INTEG_W + DW
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata,
    input  logic                  q_empty,
    input  logic [ENTRY_W-1:0]    q_data,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      compare_value,
    output logic [OUT_W-1:0]      drive_level,
    output logic                  clamped
);

`include "pid_speed_controller_top_macros.svh"

    localparam int PW_P    = GAIN_W + EW;
    localparam int PW_I    = GAIN_W + INTEG_W;
    localparam int PW_D    = GAIN_W + DW;
    localparam int SUM_W   = ((PW_I > PW_D) ? PW_I : PW_D) + 2;
    localparam int SHL     = (GAIN_FRAC_BITS <= DRIVE_FRAC_W) ? DRIVE_FRAC_W - GAIN_FRAC_BITS : 0;
    localparam int SHR     = (GAIN_FRAC_BITS > DRIVE_FRAC_W) ? GAIN_FRAC_BITS - DRIVE_FRAC_W : 0;
    localparam int ALN_W   = SUM_W + SHL;
    localparam int DRIVE_TOP = DRIVE_MAX * (2 ** DRIVE_FRAC_W);
    localparam int DRIVE_W = $clog2(DRIVE_TOP + 1);
    localparam int INC_W   = DRIVE_W + 2;  // wide enough that saturating keeps the clamp exact
    localparam int DS_W    = DRIVE_W + 3;
    localparam int LVL_W   = DRIVE_W - DRIVE_FRAC_W;

    psc_gains_t gains_reg;

    logic signed [EW-1:0]      q_err;
    logic signed [INTEG_W-1:0] q_integ;
    logic signed [DW-1:0]      q_derr;

    // product stage
    logic                  p_valid_reg;
    logic signed [PW_P-1:0] pp_reg, pp_next;
    logic signed [PW_I-1:0] pi_reg, pi_next;
    logic signed [PW_D-1:0] pd_reg, pd_next;

    // increment stage
    logic                   s_valid_reg;
    logic signed [SUM_W-1:0] sum;
    logic signed [ALN_W-1:0] aligned;
    logic [ALN_W-INC_W:0]    aln_top;
    logic signed [INC_W-1:0] inc_reg, inc_next;

    // drive / output stage
    logic                 m_valid_reg;
    logic [DRIVE_W-1:0]   drive_reg, drive_next;
    logic [DS_W-1:0]      dsum;
    logic                 under, over;
    logic [LVL_W+OUT_W-1:0] level_ext;
    logic [OUT_W-1:0]     level_next;
    logic [OUT_W-1:0]     level_reg;
    logic [OUT_W-1:0]     compare_reg;
    logic                 clamped_reg;

    logic o_ready, s_adv, s_ready, p_adv, p_ready;

    // config writes; unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GAIN_P: gains_reg.kp <= cfg_wdata;
                REG_GAIN_I: gains_reg.ki <= cfg_wdata;
                REG_GAIN_D: gains_reg.kd <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ready chain, output back to queue
    assign o_ready = !m_valid_reg || m_tready;
    assign s_adv   = s_valid_reg && o_ready;
    assign s_ready = !s_valid_reg || o_ready;
    assign p_adv   = p_valid_reg && s_ready;
    assign p_ready = !p_valid_reg || s_ready;
    assign q_pop   = !q_empty && p_ready;

    assign q_err   = q_data[EW-1:0];
    assign q_integ = q_data[EW+INTEG_W-1:EW];
    assign q_derr  = q_data[ENTRY_W-1:EW+INTEG_W];

    assign pp_next = gains_reg.kp * q_err;
    assign pi_next = gains_reg.ki * q_integ;
    assign pd_next = gains_reg.kd * q_derr;

    assign sum = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);
    assign aligned = (ALN_W'(sum) <<< SHL) >>> SHR;
    assign aln_top = aligned[ALN_W-1:INC_W-1];

    always_comb begin
        if ((&aln_top) || !(|aln_top)) begin
            inc_next = aligned[INC_W-1:0];
        end else if (aligned[ALN_W-1]) begin
            inc_next = {1'b1, {(INC_W-1){1'b0}}};
        end else begin
            inc_next = {1'b0, {(INC_W-1){1'b1}}};
        end
    end

    assign dsum  = {3'b000, drive_reg} + {{(DS_W-INC_W){inc_reg[INC_W-1]}}, inc_reg};
    assign under = dsum[DS_W-1];
    assign over  = !under && (dsum > DS_W'(DRIVE_TOP));

    always_comb begin
        if (under) begin
            drive_next = '0;
        end else if (over) begin
            drive_next = DRIVE_W'(DRIVE_TOP);
        end else begin
            drive_next = dsum[DRIVE_W-1:0];
        end
    end

    assign level_ext  = {{OUT_W{1'b0}}, drive_next[DRIVE_W-1:DRIVE_FRAC_W]};
    assign level_next = level_ext[OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            drive_reg   <= '0;
        end else begin
            if (q_pop) begin
                p_valid_reg <= 1'b1;
            end else if (p_adv) begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv) begin
                s_valid_reg <= 1'b1;
            end else if (s_adv) begin
                s_valid_reg <= 1'b0;
            end
            if (s_adv) begin
                m_valid_reg <= 1'b1;
                drive_reg   <= drive_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
        end
        if (p_adv) begin
            inc_reg <= inc_next;
        end
        if (s_adv) begin
            level_reg   <= level_next;
            compare_reg <= level_next + OUT_W'(COMPARE_OFFSET);
            clamped_reg <= under || over;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign compare_value = compare_reg;
    assign drive_level   = level_reg;
    assign clamped       = clamped_reg;

    `PSC_ASSERT(a_drive_in_range, aclk, aresetn, drive_reg <= DRIVE_W'(DRIVE_TOP))
    `PSC_ASSERT(a_clamp_at_limit, aclk, aresetn, (m_valid_reg && clamped_reg) |-> (drive_reg == '0 || drive_reg == DRIVE_W'(DRIVE_TOP)))

endmodule

>>> hw/rtl/pid_speed_controller_top.sv
// Channel   Dir  Ports                           Item
// s_        in   s_tvalid s_tready s_tdata       target/measured speed for one tick
// m_        out  m_tvalid m_tready m_tdata       PWM compare, drive level, clamp flag
// cfg_      in   cfg_wr_en cfg_addr cfg_wdata    gain register write, no handshake
//
// One item per clock sustained while m_tready is high and the back end does not stall.
// Integral and previous error update in the front in the accept cycle; the drive
// accumulator updates once per item in the last back-end stage (add + clamp).
// Reset (aresetn low, synchronous) zeroes gains, integral, previous error, drive.
// s_tready drops only when the 4-entry queue is full; m_tready low stalls the back end.
module pid_speed_controller_top import psc_pkg::*; #(
    parameter int SPEED_WIDTH    = SPEED_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int DRIVE_MAX      = DRIVE_MAX_DEF,
    parameter int COMPARE_OFFSET = COMPARE_OFFSET_DEF,
    localparam int S_TDATA_W     = ((2 * SPEED_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // target_speed, measured_speed (low bits up), zero fill
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // compare_value, drive_level, clamped (low bits up), zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata
);

    localparam int EW      = SPEED_WIDTH + 1;
    localparam int DW      = SPEED_WIDTH + 2;
    localparam int ENTRY_W = EW + INTEG_W + DW;

    logic                   q_full, q_empty, q_push, q_pop;
    logic [ENTRY_W-1:0]     q_push_data, q_pop_data;
    logic [OUT_W-1:0]       compare_value, drive_level;
    logic                   clamped;

    // front: error, saturating integral, error delta
    psc_front #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .target_speed   (s_tdata[SPEED_WIDTH-1:0]),
        .measured_speed (s_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH]),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_push_data    (q_push_data)
    );

    // decouples front from the multiply / clamp pipeline
    psc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: gain products, aligned increment, drive accumulate + clamp
    psc_back #(
        .SPEED_WIDTH    (SPEED_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DRIVE_MAX      (DRIVE_MAX),
        .COMPARE_OFFSET (COMPARE_OFFSET)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_empty       (q_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .compare_value (compare_value),
        .drive_level   (drive_level),
        .clamped       (clamped)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, clamped, drive_level, compare_value};

endmodule

>>> test/testbench.sv
module testbench import psc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPEED_W   = SPEED_WIDTH_DEF;
    localparam int S_TDATA_W = ((2 * SPEED_W + 7) / 8) * 8;

    // cfg_addr can reach one index past the gain list; writes there are dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_ZERO    = 16'h0000;
    localparam logic [GAIN_W-1:0] GAIN_ONE     = 16'h0100;  // 1.0 in Q8.8
    localparam logic [GAIN_W-1:0] GAIN_MAX_POS = 16'h7FFF;
    localparam logic [GAIN_W-1:0] GAIN_MAX_NEG = 16'h8000;

    localparam longint INTEG_HI  = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO  = -(longint'(1) <<< (INTEG_W - 1));
    localparam longint DRIVE_TOP = longint'(DRIVE_MAX_DEF) <<< DRIVE_FRAC_W;

    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASES       = 8;
    localparam int RAIL_TICKS   = 64;   // full-scale ticks per direction at the end
    localparam int MAX_REPORTS  = 40;   // cap on printed mismatches
    localparam int DRAIN_LIMIT  = 1000; // cycles allowed for the pipe to empty

    // one PWM result as it leaves m_tdata
    typedef struct {
        logic [OUT_W-1:0] compare_value;
        logic [OUT_W-1:0] drive_level;
        logic             clamped;
    } pwm_result_t;

    // Tracks the controller state (gains, integral, last error, Q.8 drive)
    // and keeps the PWM results still owed by the block, oldest first.
    class pid_drive_tracker;
        longint      kp, ki, kd;
        longint      err_integral, last_err, drive_q8;
        pwm_result_t pending_pwm[$];
        int          failures;

        function void set_gain(logic [CFG_ADDR_W-1:0] idx, logic [GAIN_W-1:0] value);
            longint g;
            g = longint'($signed(value));
            case (idx)
                REG_GAIN_P: kp = g;
                REG_GAIN_I: ki = g;
                REG_GAIN_D: kd = g;
                default: ;
            endcase
        endfunction

        // one control tick: update the loop state, queue the PWM result
        function void note_tick(logic [SPEED_W-1:0] tgt, logic [SPEED_W-1:0] meas);
            longint      err, sum, step, next;
            pwm_result_t r;
            err = longint'($signed(tgt)) - longint'($signed(meas));
            sum = err_integral + err;
            if (sum > INTEG_HI) sum = INTEG_HI;
            else if (sum < INTEG_LO) sum = INTEG_LO;
            err_integral = sum;

            step = kp * err + ki * sum + kd * (err - last_err);
            last_err = err;
            // bring gain fraction bits to the drive's 8; right shift floors
            if (GAIN_FRAC_BITS_DEF <= DRIVE_FRAC_W)
                step = step <<< (DRIVE_FRAC_W - GAIN_FRAC_BITS_DEF);
            else
                step = step >>> (GAIN_FRAC_BITS_DEF - DRIVE_FRAC_W);

            next = drive_q8 + step;
            r.clamped = 1'b0;
            if (next < 0) begin
                next = 0;
                r.clamped = 1'b1;
            end else if (next > DRIVE_TOP) begin
                next = DRIVE_TOP;
                r.clamped = 1'b1;
            end
            drive_q8 = next;
            next = next >>> DRIVE_FRAC_W;
            r.drive_level   = OUT_W'(next);
            r.compare_value = OUT_W'(next + COMPARE_OFFSET_DEF);
            pending_pwm.push_back(r);
        endfunction

        function void flag(string field, longint want, longint got);
            failures++;
            if (failures <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_pwm(logic [M_TDATA_W-1:0] word);
            pwm_result_t want;
            logic [OUT_W-1:0] got_cmp, got_lvl;
            logic got_clamp;
            got_cmp   = word[OUT_W-1:0];
            got_lvl   = word[2*OUT_W-1:OUT_W];
            got_clamp = word[2*OUT_W];
            if (pending_pwm.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $error("result with nothing pending: compare_value %0d", got_cmp);
                return;
            end
            want = pending_pwm.pop_front();
            if (got_cmp !== want.compare_value)
                flag("compare_value", want.compare_value, got_cmp);
            if (got_lvl !== want.drive_level)
                flag("drive_level", want.drive_level, got_lvl);
            if (got_clamp !== want.clamped)
                flag("clamped", want.clamped, got_clamp);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // target_speed, measured_speed
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // compare_value, drive_level, clamped
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [GAIN_W-1:0]     cfg_wdata = '0;

    // no idle bursts on either side while set
    bit calm = 1'b0;

    pid_drive_tracker tracker = new();

    pid_speed_controller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Both channels sampled on the edge, before any NBA of that edge lands.
    // Output is checked before the same-edge input is noted, so a result
    // can never match an item taken in the same cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                tracker.check_pwm(m_tdata);
            if (s_tvalid && s_tready)
                tracker.note_tick(s_tdata[SPEED_W-1:0], s_tdata[2*SPEED_W-1:SPEED_W]);
        end
    end

    // Result side back-pressure: random stall bursts, none while calm is set.
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offer one item, maybe after an idle burst, and hold it until taken.
    // tvalid stays high on return so back-to-back items need no toggle.
    task automatic send_tick(int tgt, int meas);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({SPEED_W'(meas), SPEED_W'(tgt)});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mostly near-setpoint ticks so the drive stays off the rails;
    // the rest are full-range speeds.
    task automatic send_random_tick();
        logic [SPEED_W-1:0] tgt, meas;
        tgt = SPEED_W'($urandom);
        if ($urandom_range(0, 9) < 7)
            meas = tgt + SPEED_W'($urandom_range(0, 127) - 64);
        else
            meas = SPEED_W'($urandom);
        send_tick(int'(tgt), int'(meas));
    endtask

    // Stop offering, wait for every owed result, then a few spare cycles
    // so the pipe is truly idle before any register write.
    // The first edge lets the monitor note the last item taken.
    task automatic drain_pipeline();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_pwm.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (tracker.pending_pwm.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_pwm.size());
            tracker.failures += tracker.pending_pwm.size();
            tracker.pending_pwm.delete();
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_gain(logic [CFG_ADDR_W-1:0] idx, logic [GAIN_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_gain(idx, value);
    endtask

    // All three gains, then a junk write to the unused index that must
    // leave them alone.
    task automatic write_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                               logic [GAIN_W-1:0] d);
        write_gain(REG_GAIN_P, p);
        write_gain(REG_GAIN_I, i);
        write_gain(REG_GAIN_D, d);
        write_gain(REG_UNUSED, GAIN_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] small_gain(int span);
        return GAIN_W'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic load_phase_gains(int phase);
        case (phase)
            0:       write_gains(GAIN_ONE, GAIN_ZERO, GAIN_ZERO);
            2:       write_gains(GAIN_MAX_POS, GAIN_MAX_NEG, GAIN_MAX_POS);
            3:       write_gains(GAIN_MAX_NEG, GAIN_MAX_POS, GAIN_MAX_NEG);
            4:       write_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
            6:       write_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
            default: write_gains(small_gain(512), small_gain(8), small_gain(512));
        endcase
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: pure P at 1.0, drive walks to both rails ---
        write_gains(GAIN_ONE, GAIN_ZERO, GAIN_ZERO);
        send_tick(800, 0);         // lands exactly on the top rail, no clamp
        send_tick(0, 0);           // zero error, drive holds at the rail
        send_tick(0, 800);         // lands exactly on zero, no clamp
        send_tick(-1, 0);          // just below zero, clamps low
        send_tick(5, 0);
        send_tick(32767, -32768);  // largest positive error, clamps high
        send_tick(-32768, 32767);  // largest negative error, clamps low
        send_tick(-1, -1);
        send_tick(32767, 32767);
        send_tick(-32768, -32768);
        drain_pipeline();

        // derivative alone: steady error gives no kick after the first tick
        write_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ONE);
        send_tick(100, 0);
        send_tick(100, 0);
        send_tick(0, 50);
        drain_pipeline();

        // integral alone
        write_gains(GAIN_ZERO, GAIN_ONE, GAIN_ZERO);
        send_tick(10, 0);
        send_tick(10, 0);
        send_tick(-25, 0);
        drain_pipeline();

        // most negative P gain
        write_gains(GAIN_MAX_NEG, GAIN_ZERO, GAIN_ZERO);
        send_tick(0, 1);
        send_tick(1, 0);
        drain_pipeline();

        // --- random phases, each under its own gain set ---
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = ($urandom_range(0, 3) == 0);
            load_phase_gains(ph);
            repeat (RANDOM_ITEMS / PHASES) send_random_tick();
            drain_pipeline();
        end

        // --- last part, no idling: full-scale error one way, then the other ---
        // Tiny I gain only; the integral swings wide one way, then back
        // the other way.
        calm = 1'b1;
        write_gains(GAIN_ZERO, 16'h0001, GAIN_ZERO);
        repeat (RAIL_TICKS) send_tick(32767, -32768);
        repeat (RAIL_TICKS) send_tick(-32768, 32767);
        drain_pipeline();

        write_gains(small_gain(512), small_gain(8), small_gain(512));
        repeat (20) send_random_tick();
        drain_pipeline();

        if (tracker.failures == 0)
            $display("pid_speed_controller_top: match");
        else
            $display("pid_speed_controller_top: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("pid_speed_controller_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/psc_pkg.sv
hw/rtl/psc_front.sv
hw/rtl/psc_queue.sv
hw/rtl/psc_back.sv
hw/rtl/pid_speed_controller_top.sv
test/testbench.sv
